@@ sv/edd_pkg.sv @@
package edd_pkg;

    // Line store geometry and field widths.
    localparam int MAX_WIDTH   = 2048;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int WIDTH_W     = 12;
    localparam int NUM_CH      = 3;
    localparam int ERR_W       = 14;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(640);
    localparam logic [WIDTH_W-1:0] WIDTH_MIN   = WIDTH_W'(2);
    localparam logic [WIDTH_W-1:0] WIDTH_MAX   = WIDTH_W'(MAX_WIDTH);

    // One error value in sixteenths of a level, and one per channel.
    typedef logic signed [ERR_W-1:0] t_err;
    typedef t_err [NUM_CH-1:0] t_err3;

    // Input request as it arrives on the port.
    typedef struct packed {
        logic       start_of_frame;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_pix_in;

    // Result as it leaves on the port.
    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       end_of_row;
    } t_pix_out;

    // Classified request handed from the front to the back.
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             last;
        logic             first_row;
        logic             clear;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
    } t_job;

endpackage

@@ sv/edd_front.sv @@
module edd_front
    import edd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [WIDTH_W-1:0]  i_cfg_data,
    input  logic                i_accept,
    input  t_pix_in             i_pix,
    output t_job                o_job
);

    logic [WIDTH_W-1:0] r_width;
    logic [COL_W-1:0]   r_col;
    logic               r_first_row;
    logic [COL_W-1:0]   n_col;
    logic               n_first_row;
    logic [WIDTH_W-1:0] w_eff;
    logic [COL_W-1:0]   x;
    logic               fr;
    logic               clear;
    logic               last;

    // Image width register; the user must write it only while idle, the block does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WIDTH_RESET;
        end else if (i_cfg_valid) begin
            r_width <= i_cfg_data;
        end
    end

    // Clamp the programmed width into the range the line store supports.
    always_comb begin
        if (r_width < WIDTH_MIN) begin
            w_eff = WIDTH_MIN;
        end else if (r_width > WIDTH_MAX) begin
            w_eff = WIDTH_MAX;
        end else begin
            w_eff = r_width;
        end
    end

    // Place the request in the raster: column, row restart and last column.
    always_comb begin
        if (i_pix.start_of_frame) begin
            x     = '0;
            fr    = 1'b1;
            clear = 1'b1;
        end else if (WIDTH_W'(r_col) >= w_eff) begin
            x     = '0;
            fr    = 1'b0;
            clear = 1'b1;
        end else begin
            x     = r_col;
            fr    = r_first_row;
            clear = 1'b0;
        end
        last = (WIDTH_W'(x) + WIDTH_W'(1)) >= w_eff;
        if (last) begin
            n_col       = '0;
            n_first_row = 1'b0;
        end else begin
            n_col       = x + COL_W'(1);
            n_first_row = fr;
        end
    end

    // Raster position advances with each accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_first_row <= 1'b1;
        end else if (i_accept) begin
            r_col       <= n_col;
            r_first_row <= n_first_row;
        end
    end

    assign o_job.col       = x;
    assign o_job.last      = last;
    assign o_job.first_row = fr;
    assign o_job.clear     = clear;
    assign o_job.red       = i_pix.red_in;
    assign o_job.green     = i_pix.green_in;
    assign o_job.blue      = i_pix.blue_in;

endmodule

@@ sv/edd_queue.sv @@
module edd_queue
    import edd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_job
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_slot[r_rd_ptr];

    // Storage slots carry payload only.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ sv/edd_back.sv @@
module edd_back
    import edd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_q_valid,
    input  t_job     i_q_job,
    output logic     o_pop,
    output logic     o_out_valid,
    output t_pix_out o_out_data,
    input  logic     i_out_stall
);

    localparam int SUM_W  = 16;
    localparam int PROD_W = 18;

    localparam logic signed [SUM_W-1:0] HALF_LEVEL = SUM_W'(2040);
    localparam logic signed [SUM_W-1:0] FULL_LEVEL = SUM_W'(4080);
    localparam logic signed [SUM_W-1:0] ERR_MAX    = SUM_W'((1 << (ERR_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] ERR_MIN    = -SUM_W'(1 << (ERR_W - 1));

    typedef struct packed {
        logic level;
        t_err s7;
        t_err s5;
        t_err s3;
        t_err s1;
    } t_chan_res;

    // Clamp a wide sum to the error range.
    function automatic t_err f_sat(input logic signed [SUM_W-1:0] v);
        t_err r;
        if (v > ERR_MAX) begin
            r = ERR_MAX[ERR_W-1:0];
        end else if (v < ERR_MIN) begin
            r = ERR_MIN[ERR_W-1:0];
        end else begin
            r = v[ERR_W-1:0];
        end
        return r;
    endfunction

    // k/16 of an error, rounded to the nearest sixteenth with halves up.
    function automatic t_err f_share(input t_err e, input logic signed [PROD_W-1:0] k);
        logic signed [PROD_W-1:0] p;
        p = PROD_W'(e) * k + PROD_W'(8);
        return p[ERR_W+3:4];
    endfunction

    // Quantize one channel and split its residual error.
    function automatic t_chan_res f_chan(input logic [7:0] s, input t_err carry,
                                         input t_err above);
        logic signed [SUM_W-1:0] v;
        logic signed [SUM_W-1:0] d;
        t_err                    e;
        t_chan_res               r;
        v = $signed({4'b0000, s, 4'b0000}) + SUM_W'(carry) + SUM_W'(above);
        r.level = (v >= HALF_LEVEL);
        d = r.level ? (v - FULL_LEVEL) : v;
        e = f_sat(d);
        r.s7 = f_share(e, PROD_W'(7));
        r.s5 = f_share(e, PROD_W'(5));
        r.s3 = f_share(e, PROD_W'(3));
        r.s1 = f_share(e, PROD_W'(1));
        return r;
    endfunction

    // Line store: one word of three channel errors per column.
    t_err3            r_line_mem [MAX_WIDTH];

    logic             r_b2_valid;
    t_job             r_b2_job;
    t_err3            r_above;
    t_err3            r_rc;
    t_err3            r_bp;
    t_err3            r_held;
    logic [COL_W-1:0] r_hold_addr;
    logic             r_hold_valid;
    logic             r_out_valid;
    t_pix_out         r_out_data;

    logic             adv;
    logic [7:0]       sample [NUM_CH];
    t_chan_res        res    [NUM_CH];
    t_err3            n_rc;
    t_err3            n_bp;
    t_err3            n_held;
    t_err3            upd_left;
    t_err             rc_eff;
    t_err             bp_eff;
    t_err             above_eff;
    logic             wr_en;
    logic [COL_W-1:0] wr_addr;
    t_err3            wr_data;
    logic             bypass;

    // The compute stage moves when the output register is free or being taken.
    assign adv   = r_b2_valid && (!r_out_valid || !i_out_stall);
    assign o_pop = i_q_valid && (!r_b2_valid || adv);

    assign sample[0] = r_b2_job.red;
    assign sample[1] = r_b2_job.green;
    assign sample[2] = r_b2_job.blue;

    // Per-channel quantization and error split.
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            rc_eff    = r_b2_job.clear ? t_err'(0) : r_rc[c];
            bp_eff    = r_b2_job.clear ? t_err'(0) : r_bp[c];
            above_eff = r_b2_job.first_row ? t_err'(0) : r_above[c];
            res[c]    = f_chan(sample[c], rc_eff, above_eff);
            n_held[c]   = f_sat(SUM_W'(bp_eff) + SUM_W'(res[c].s5));
            upd_left[c] = f_sat(SUM_W'(r_held[c]) + SUM_W'(res[c].s3));
            n_rc[c]     = r_b2_job.last ? t_err'(0) : res[c].s7;
            n_bp[c]     = r_b2_job.last ? t_err'(0) : res[c].s1;
        end
    end

    // Retire the entry left of this pixel, or flush the last entry of a
    // finished row when this pixel opens a new row.
    always_comb begin
        if (r_b2_job.col != '0) begin
            wr_en   = adv;
            wr_addr = r_b2_job.col - COL_W'(1);
            wr_data = upd_left;
        end else begin
            wr_en   = adv && r_hold_valid;
            wr_addr = r_hold_addr;
            wr_data = r_held;
        end
        bypass = wr_en && (wr_addr == i_q_job.col);
    end

    // Line store write and registered read, forwarding a same-cycle write.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_line_mem[wr_addr] <= wr_data;
        end
        if (o_pop) begin
            r_above <= bypass ? wr_data : r_line_mem[i_q_job.col];
        end
    end

    // Compute stage holding register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b2_valid <= 1'b0;
        end else if (o_pop) begin
            r_b2_valid <= 1'b1;
        end else if (adv) begin
            r_b2_valid <= 1'b0;
        end
        if (o_pop) begin
            r_b2_job <= i_q_job;
        end
    end

    // Carries and the entry below the current pixel still open for update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rc         <= '0;
            r_bp         <= '0;
            r_hold_valid <= 1'b0;
        end else if (adv) begin
            r_rc         <= n_rc;
            r_bp         <= n_bp;
            r_hold_valid <= 1'b1;
        end
        if (adv) begin
            r_held      <= n_held;
            r_hold_addr <= r_b2_job.col;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (adv) begin
            r_out_data.red_out    <= res[0].level ? 8'hFF : 8'h00;
            r_out_data.green_out  <= res[1].level ? 8'hFF : 8'h00;
            r_out_data.blue_out   <= res[2].level ? 8'hFF : 8'h00;
            r_out_data.end_of_row <= r_b2_job.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ sv/error_diffusion_dither_rgb.sv @@
// A taken pixel passes the queue slot, the compute stage and the output register.
// Throughput: one pixel per clock unless the output stalls, set by the right-carry
// loop in the compute stage and one line store write and one read per cycle.
// Reset (synchronous, active low) clears the queue, carries, raster position and
// valid flags and sets the width to 640; the line store is not cleared.
module error_diffusion_dither_rgb
    import edd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_pix_in            i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_pix_out           o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [WIDTH_W-1:0] i_cfg_data
);

    logic in_accept;
    logic q_full;
    logic q_valid;
    logic q_pop;
    t_job front_job;
    t_job q_job;

    // A request is taken whenever the queue has room.
    assign o_in_stall  = q_full;
    assign in_accept   = i_in_valid && !q_full;
    assign o_cfg_ready = 1'b1;

    edd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (in_accept),
        .i_pix       (i_in_data),
        .o_job       (front_job)
    );

    edd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    edd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_job     (q_job),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

@@ verif/error_diffusion_dither_rgb_test.sv @@
`timescale 1ns / 1ps

module error_diffusion_dither_rgb_test;
    import edd_pkg::*;

    localparam int HALF_LEVEL    = 2040;
    localparam int ERR_HI        = 8191;
    localparam int ERR_LO        = -8192;
    localparam logic [7:0] LEVEL_HIGH = 8'd255;
    localparam logic [7:0] LEVEL_LOW  = 8'd0;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 4;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    t_pix_in            i_in_data = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_pix_out           o_out_data;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [WIDTH_W-1:0] i_cfg_data = '0;

    // Pixel requests waiting to be sent and dithered pixels waiting to arrive.
    t_pix_in  pixel_backlog [$];
    t_pix_out want_pixels [$];
    t_pix_out want_now;

    // Shadow of the block's register and error state.
    logic [WIDTH_W-1:0] row_width_reg = WIDTH_RESET;
    t_err line_err [MAX_WIDTH][NUM_CH];
    t_err carry_right [NUM_CH];
    t_err carry_below [NUM_CH];
    int   pix_col = 0;
    bit   in_first_row = 1'b1;

    // Raster position as seen by the stimulus generator.
    int gen_col = 0;
    bit gen_first = 1'b1;
    int gen_written = 0;

    int  mismatch_count = 0;
    int  idle_cycles = 0;
    bit  idle_on = 1'b1;
    int  gap_left = 0;
    int  stall_left = 0;

    wire in_fire  = i_in_valid && !o_in_stall;
    wire out_fire = o_out_valid && !i_out_stall;
    wire cfg_fire = i_cfg_valid && o_cfg_ready;

    error_diffusion_dither_rgb u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Width that the block actually uses for a given register value.
    function automatic int eff_width(logic [WIDTH_W-1:0] raw);
        if (raw < WIDTH_MIN) return int'(WIDTH_MIN);
        if (raw > WIDTH_MAX) return int'(WIDTH_MAX);
        return int'(raw);
    endfunction

    function automatic int sat_err(int v);
        if (v > ERR_HI) return ERR_HI;
        if (v < ERR_LO) return ERR_LO;
        return v;
    endfunction

    // k/16 of an error, rounded to the nearest sixteenth with halves up.
    function automatic int share_of(int k, int e);
        return (k * e + 8) >>> 4;
    endfunction

    function automatic void clear_carries();
        for (int k = 0; k < NUM_CH; k++) begin
            carry_right[k] = '0;
            carry_below[k] = '0;
        end
    endfunction

    // Dither one pixel and advance the shadow state.
    function automatic t_pix_out dither_pixel(t_pix_in px);
        int w;
        int x;
        int v;
        int e;
        int above;
        int samp [NUM_CH];
        logic [7:0] lvl [NUM_CH];
        bit last;
        t_pix_out res;
        w = eff_width(row_width_reg);
        if (px.start_of_frame) begin
            pix_col = 0;
            in_first_row = 1'b1;
            clear_carries();
        end else if (pix_col >= w) begin
            pix_col = 0;
            in_first_row = 1'b0;
            clear_carries();
        end
        x = pix_col;
        last = (x + 1 >= w);
        samp[0] = int'(px.red_in);
        samp[1] = int'(px.green_in);
        samp[2] = int'(px.blue_in);
        for (int k = 0; k < NUM_CH; k++) begin
            above = in_first_row ? 0 : int'(line_err[x][k]);
            v = samp[k] * 16 + int'(carry_right[k]) + above;
            lvl[k] = (v >= HALF_LEVEL) ? LEVEL_HIGH : LEVEL_LOW;
            e = sat_err(v - int'(lvl[k]) * 16);
            if (x > 0) begin
                line_err[x-1][k] = t_err'(sat_err(int'(line_err[x-1][k]) + share_of(3, e)));
            end
            line_err[x][k] = t_err'(sat_err(int'(carry_below[k]) + share_of(5, e)));
            carry_right[k] = last ? t_err'(0) : t_err'(sat_err(share_of(7, e)));
            carry_below[k] = last ? t_err'(0) : t_err'(sat_err(share_of(1, e)));
        end
        res.red_out = lvl[0];
        res.green_out = lvl[1];
        res.blue_out = lvl[2];
        res.end_of_row = last;
        if (last) begin
            pix_col = 0;
            in_first_row = 1'b0;
            clear_carries();
        end else begin
            pix_col = x + 1;
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want_v);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want_v);
        mismatch_count++;
    endtask

    // Queue a pixel. A start of frame is forced wherever the pixel would read
    // a line store entry that has never been written since reset.
    task automatic add_pixel(bit sof, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int x;
        bit first;
        int w;
        t_pix_in px;
        w = eff_width(row_width_reg);
        if (sof) begin
            x = 0;
            first = 1'b1;
        end else if (gen_col >= w) begin
            x = 0;
            first = 1'b0;
        end else begin
            x = gen_col;
            first = gen_first;
        end
        if (!first && x >= gen_written) begin
            sof = 1'b1;
            x = 0;
            first = 1'b1;
        end
        if (x + 1 > gen_written) gen_written = x + 1;
        if (x + 1 >= w) begin
            gen_col = 0;
            gen_first = 1'b0;
        end else begin
            gen_col = x + 1;
            gen_first = first;
        end
        px.start_of_frame = sof;
        px.red_in = r;
        px.green_in = g;
        px.blue_in = b;
        pixel_backlog.push_back(px);
    endtask

    // Mostly full-range samples, with the extremes and the threshold region favored.
    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'($urandom_range(120, 135));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_random_pixel(bit sof);
        add_pixel(sof, pick_level(), pick_level(), pick_level());
    endtask

    // Sample the traffic state away from the rising edge so it has settled.
    task automatic wait_idle();
        @(negedge i_clk);
        while (pixel_backlog.size() != 0 || i_in_valid || want_pixels.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write the width register once the block has gone quiet.
    task automatic set_width(logic [WIDTH_W-1:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        row_width_reg = value;
    endtask

    // Request driver: sends queued pixels, predicts each one as it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (in_fire) begin
                want_pixels.push_back(dither_pixel(i_in_data));
            end
            if (!i_in_valid || in_fire) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pixel_backlog.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= pixel_backlog.pop_front();
                    if (idle_on && $urandom_range(0, 7) == 0) begin
                        gap_left = $urandom_range(1, 10);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each dithered pixel and applies back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_fire) begin
                if (want_pixels.size() == 0) begin
                    report_mismatch("pixel with none expected", 0, 0);
                end else begin
                    want_now = want_pixels.pop_front();
                    if (o_out_data.red_out !== want_now.red_out)
                        report_mismatch("red_out", o_out_data.red_out, want_now.red_out);
                    if (o_out_data.green_out !== want_now.green_out)
                        report_mismatch("green_out", o_out_data.green_out, want_now.green_out);
                    if (o_out_data.blue_out !== want_now.blue_out)
                        report_mismatch("blue_out", o_out_data.blue_out, want_now.blue_out);
                    if (o_out_data.end_of_row !== want_now.end_of_row)
                        report_mismatch("end_of_row", o_out_data.end_of_row,
                                        want_now.end_of_row);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 9);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles in which no channel moves anything.
    always @(posedge i_clk) begin
        if (!i_rst_n || in_fire || out_fire || cfg_fire) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int w;
        int n;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset width: start a frame with the extremes and stop mid-row.
        add_pixel(1'b1, 8'd0, 8'd0, 8'd0);
        add_pixel(1'b0, 8'd255, 8'd255, 8'd255);
        add_pixel(1'b0, 8'd128, 8'd127, 8'd128);
        add_pixel(1'b0, 8'd127, 8'd128, 8'd127);
        add_pixel(1'b0, 8'd255, 8'd0, 8'd128);

        // Shrinking below the current column starts a new row that reads errors.
        set_width(12'd3);
        add_pixel(1'b0, 8'd200, 8'd50, 8'd100);
        add_pixel(1'b0, 8'd0, 8'd255, 8'd127);
        add_pixel(1'b1, 8'd128, 8'd128, 8'd128);
        add_pixel(1'b0, 8'd255, 8'd0, 8'd0);
        add_pixel(1'b0, 8'd0, 8'd0, 8'd255);
        add_pixel(1'b0, 8'd127, 8'd127, 8'd127);
        add_pixel(1'b0, 8'd1, 8'd254, 8'd64);
        add_pixel(1'b0, 8'd255, 8'd255, 8'd255);

        // Widths below the minimum act as two pixels.
        set_width(12'd0);
        add_pixel(1'b0, 8'd100, 8'd150, 8'd200);
        add_pixel(1'b0, 8'd255, 8'd0, 8'd255);
        add_pixel(1'b0, 8'd0, 8'd255, 8'd0);
        set_width(12'd1);
        add_pixel(1'b0, 8'd128, 8'd0, 8'd255);
        add_pixel(1'b0, 8'd64, 8'd192, 8'd32);
        add_pixel(1'b0, 8'd127, 8'd128, 8'd129);

        // All-ones width clamps to the line store size; a short run must not end a row.
        set_width(12'd4095);
        add_random_pixel(1'b1);
        for (int i = 0; i < 39; i++) add_random_pixel(1'b0);
        set_width(WIDTH_MAX);
        for (int i = 0; i < 6; i++) add_random_pixel(1'b0);

        // Random frames at mostly small widths; the third and the last two phases run without idling.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: w = 2;
                1: w = $urandom_range(3, 8);
                2: w = $urandom_range(9, 40);
                default: w = $urandom_range(41, 200);
            endcase
            set_width(WIDTH_W'(w));
            idle_on = (ph < 6) && (ph != 2);
            n = $urandom_range(35, 50);
            add_random_pixel($urandom_range(0, 1) == 0);
            for (int i = 1; i < n; i++) add_random_pixel($urandom_range(0, 39) == 0);
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
